[design/sbt_pkg.sv]
// shared types, codes and helpers for the source byte tokenizer
package sbt_pkg;

  localparam int COUNT_BITS = 16;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef logic [COUNT_BITS-1:0] cnt_t;

  // scan modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_SLASH   = 4'd1;
  localparam logic [3:0] M_COMMENT = 4'd2;
  localparam logic [3:0] M_IDENT   = 4'd3;
  localparam logic [3:0] M_NUMBER  = 4'd4;
  localparam logic [3:0] M_STRING  = 4'd5;
  localparam logic [3:0] M_STRESC  = 4'd6;
  localparam logic [3:0] M_COLOR   = 4'd7;
  localparam logic [3:0] M_EQ      = 4'd8;
  localparam logic [3:0] M_BANG    = 4'd9;
  localparam logic [3:0] M_GT      = 4'd10;
  localparam logic [3:0] M_LT      = 4'd11;

  // token kinds
  localparam logic [4:0] K_EOF     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_NUMBER  = 5'd2;
  localparam logic [4:0] K_STRING  = 5'd3;
  localparam logic [4:0] K_COLOR   = 5'd4;
  localparam logic [4:0] K_EQ      = 5'd5;
  localparam logic [4:0] K_EQEQ    = 5'd6;
  localparam logic [4:0] K_DOT     = 5'd7;
  localparam logic [4:0] K_LBRACK  = 5'd8;
  localparam logic [4:0] K_RBRACK  = 5'd9;
  localparam logic [4:0] K_LPAREN  = 5'd10;
  localparam logic [4:0] K_RPAREN  = 5'd11;
  localparam logic [4:0] K_COLON   = 5'd12;
  localparam logic [4:0] K_COMMA   = 5'd13;
  localparam logic [4:0] K_PLUS    = 5'd14;
  localparam logic [4:0] K_MINUS   = 5'd15;
  localparam logic [4:0] K_STAR    = 5'd16;
  localparam logic [4:0] K_SLASH   = 5'd17;
  localparam logic [4:0] K_PERCENT = 5'd18;
  localparam logic [4:0] K_NE      = 5'd19;
  localparam logic [4:0] K_GT      = 5'd20;
  localparam logic [4:0] K_GE      = 5'd21;
  localparam logic [4:0] K_LT      = 5'd22;
  localparam logic [4:0] K_LE      = 5'd23;
  localparam logic [4:0] K_ERROR   = 5'd24;

  // input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // special bytes
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
  } byte_word_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        last_of_run;
  } token_word_t;

  // results of one scan step, up to two tokens
  typedef struct packed {
    logic [1:0]  count;
    token_word_t first;
    token_word_t second;
  } scan_out_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic [15:0] clip16(input cnt_t v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h2E: k = K_DOT;
      8'h5B: k = K_LBRACK;
      8'h5D: k = K_RBRACK;
      8'h28: k = K_LPAREN;
      8'h29: k = K_RPAREN;
      8'h3A: k = K_COLON;
      8'h2C: k = K_COMMA;
      8'h2B: k = K_PLUS;
      8'h2D: k = K_MINUS;
      8'h2A: k = K_STAR;
      8'h25: k = K_PERCENT;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

endpackage

[design/sbt_scan.sv]
// scan state, position counters and per-byte token decision
module sbt_scan import sbt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  byte_word_t word,
  output scan_out_t  result
);

  logic [3:0] scan_mode, scan_mode_next;
  cnt_t byte_offset, byte_offset_next;
  cnt_t line_count, line_count_next;
  cnt_t column_count, column_count_next;
  cnt_t tok_start_off, tok_start_off_next;
  cnt_t tok_start_line, tok_start_line_next;
  cnt_t tok_start_col, tok_start_col_next;
  cnt_t tok_len, tok_len_next;

  logic [7:0] c;
  cnt_t       len_inc;
  logic       p_en;
  logic [4:0] p_kind;
  cnt_t       p_len;
  logic       do_idle;
  logic       s_en;
  logic [4:0] s_kind;
  logic       s_eof;
  logic       idle_mark;
  logic [3:0] idle_mode;
  token_word_t pend_tok, sec_tok;

  assign c       = word.byte_value;
  assign len_inc = sat_inc(tok_len);

  // classify c as the first byte of a new token
  always_comb begin
    idle_mark = 1'b1;
    idle_mode = M_IDLE;
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
      idle_mark = 1'b0;
    end else if (is_alpha(c) || c == CH_UNDER) begin
      idle_mode = M_IDENT;
    end else if (is_digit(c)) begin
      idle_mode = M_NUMBER;
    end else if (c == CH_QUOTE) begin
      idle_mode = M_STRING;
    end else if (c == CH_HASH) begin
      idle_mode = M_COLOR;
    end else if (c == CH_SLASH) begin
      idle_mode = M_SLASH;
    end else if (c == CH_EQUAL) begin
      idle_mode = M_EQ;
    end else if (c == CH_BANG) begin
      idle_mode = M_BANG;
    end else if (c == CH_GT) begin
      idle_mode = M_GT;
    end else if (c == CH_LT) begin
      idle_mode = M_LT;
    end else begin
      idle_mark = 1'b0;
    end
  end

  always_comb begin
    scan_mode_next      = scan_mode;
    tok_len_next        = tok_len;
    tok_start_off_next  = tok_start_off;
    tok_start_line_next = tok_start_line;
    tok_start_col_next  = tok_start_col;
    p_en    = 1'b0;
    p_kind  = K_ERROR;
    p_len   = tok_len;
    do_idle = 1'b0;
    s_en    = 1'b0;
    s_eof   = 1'b0;
    s_kind  = single_kind(c);

    if (word.action == ACT_END) begin
      p_en = 1'b1;
      case (scan_mode)
        M_IDENT:  p_kind = K_IDENT;
        M_NUMBER: p_kind = K_NUMBER;
        M_COLOR:  p_kind = K_COLOR;
        M_STRING, M_STRESC, M_BANG: p_kind = K_ERROR;
        M_SLASH:  p_kind = K_SLASH;
        M_EQ:     p_kind = K_EQ;
        M_GT:     p_kind = K_GT;
        M_LT:     p_kind = K_LT;
        default:  p_en = 1'b0;
      endcase
      s_en   = 1'b1;
      s_eof  = 1'b1;
      s_kind = K_EOF;
      scan_mode_next      = M_IDLE;
      tok_len_next        = '0;
      tok_start_off_next  = '0;
      tok_start_line_next = cnt_t'(1);
      tok_start_col_next  = cnt_t'(1);
    end else begin
      case (scan_mode)
        M_IDLE: do_idle = 1'b1;
        M_SLASH: begin
          if (c == CH_SLASH) begin
            scan_mode_next = M_COMMENT;
          end else begin
            p_en = 1'b1; p_kind = K_SLASH; do_idle = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_LF) scan_mode_next = M_IDLE;
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
            tok_len_next = len_inc;
          end else begin
            p_en = 1'b1; p_kind = K_IDENT; do_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(c)) begin
            tok_len_next = len_inc;
          end else begin
            p_en = 1'b1; p_kind = K_NUMBER; do_idle = 1'b1;
          end
        end
        M_COLOR: begin
          if (is_alpha(c) || is_digit(c)) begin
            tok_len_next = len_inc;
          end else begin
            p_en = 1'b1; p_kind = K_COLOR; do_idle = 1'b1;
          end
        end
        M_STRING: begin
          tok_len_next = len_inc;
          if (c == CH_QUOTE) begin
            p_en = 1'b1; p_kind = K_STRING; p_len = len_inc;
            scan_mode_next = M_IDLE;
          end else if (c == CH_BSLASH) begin
            scan_mode_next = M_STRESC;
          end
        end
        M_STRESC: begin
          tok_len_next   = len_inc;
          scan_mode_next = M_STRING;
        end
        M_EQ, M_BANG, M_GT, M_LT: begin
          if (c == CH_EQUAL) begin
            p_en = 1'b1; p_len = len_inc; tok_len_next = len_inc;
            scan_mode_next = M_IDLE;
            case (scan_mode)
              M_EQ:    p_kind = K_EQEQ;
              M_BANG:  p_kind = K_NE;
              M_GT:    p_kind = K_GE;
              default: p_kind = K_LE;
            endcase
          end else begin
            p_en = 1'b1; do_idle = 1'b1;
            case (scan_mode)
              M_EQ:    p_kind = K_EQ;
              M_BANG:  p_kind = K_ERROR;
              M_GT:    p_kind = K_GT;
              default: p_kind = K_LT;
            endcase
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        scan_mode_next = idle_mode;
        if (idle_mark) begin
          tok_start_off_next  = byte_offset;
          tok_start_line_next = line_count;
          tok_start_col_next  = column_count;
          tok_len_next        = cnt_t'(1);
        end else if (c != CH_SPACE && c != CH_TAB && c != CH_CR && c != CH_LF) begin
          s_en = 1'b1;
        end
      end
    end
  end

  // position counters
  always_comb begin
    if (word.action == ACT_END) begin
      byte_offset_next  = '0;
      line_count_next   = cnt_t'(1);
      column_count_next = cnt_t'(1);
    end else begin
      byte_offset_next = sat_inc(byte_offset);
      if (c == CH_LF) begin
        line_count_next   = sat_inc(line_count);
        column_count_next = cnt_t'(1);
      end else begin
        line_count_next   = line_count;
        column_count_next = sat_inc(column_count);
      end
    end
  end

  always_comb begin
    pend_tok.token_kind   = p_kind;
    pend_tok.start_offset = clip16(tok_start_off);
    pend_tok.token_length = clip16(p_len);
    pend_tok.start_line   = clip16(tok_start_line);
    pend_tok.start_column = clip16(tok_start_col);
    pend_tok.last_of_run  = ~s_en;

    sec_tok.token_kind   = s_kind;
    sec_tok.start_offset = clip16(byte_offset);
    sec_tok.token_length = s_eof ? 16'd0 : 16'd1;
    sec_tok.start_line   = clip16(line_count);
    sec_tok.start_column = clip16(column_count);
    sec_tok.last_of_run  = 1'b1;

    result.count  = {1'b0, p_en} + {1'b0, s_en};
    result.first  = p_en ? pend_tok : sec_tok;
    result.second = sec_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= M_IDLE;
      byte_offset    <= '0;
      line_count     <= cnt_t'(1);
      column_count   <= cnt_t'(1);
      tok_start_off  <= '0;
      tok_start_line <= cnt_t'(1);
      tok_start_col  <= cnt_t'(1);
      tok_len        <= '0;
    end else if (take) begin
      scan_mode      <= scan_mode_next;
      byte_offset    <= byte_offset_next;
      line_count     <= line_count_next;
      column_count   <= column_count_next;
      tok_start_off  <= tok_start_off_next;
      tok_start_line <= tok_start_line_next;
      tok_start_col  <= tok_start_col_next;
      tok_len        <= tok_len_next;
    end
  end

endmodule

[design/sbt_queue.sv]
// token queue: in up to two words per cycle, out one unless stall
module sbt_queue import sbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  scan_out_t   wr,
  output logic        full,
  output logic        valid,
  input  logic        stall,
  output token_word_t word
);

  token_word_t mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count, count_next;
  logic [QPTR_BITS-1:0] wr_ptr1;
  logic [1:0]           n_push;
  logic                 pop;

  assign n_push  = push ? wr.count : 2'd0;
  assign pop     = valid & ~stall;
  assign wr_ptr1 = wr_ptr + QPTR_BITS'(1);
  assign valid   = (count != '0);
  // room for two words is needed before a byte is taken
  assign full    = (count > QCNT_BITS'(QDEPTH - 2));
  assign word    = mem[rd_ptr];

  always_comb begin
    count_next = count + QCNT_BITS'(n_push) - QCNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem[wr_ptr] <= wr.first;
    if (n_push == 2'd2) mem[wr_ptr1] <= wr.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_BITS'(n_push);
      rd_ptr <= rd_ptr + QPTR_BITS'(pop);
      count  <= count_next;
    end
  end

endmodule

[design/source_byte_tokenizer.sv]
// top level of the streaming source byte tokenizer
//
//  channel  direction  handshake             word
//  byte     in         byte_valid/stall      byte_word_t  (action, byte_value)
//  token    out        token_valid/stall     token_word_t (kind, offset, length,
//                                                          line, column, last_of_run)
//
// one byte word is taken per cycle while byte_stall is low; it yields zero, one or two tokens
// the scan state and counters update in the cycle the byte is taken, the
// tokens land in a four-entry queue and leave one per cycle from the next
// while token_stall is low; byte_stall is high while the queue holds three or
// more tokens, leaving no room for a two-token byte; with the receiver ready,
// bytes of one token or none run one per cycle, runs of two-token bytes stall
// reset (rst, synchronous) empties the queue and returns the scanner to
// idle at offset 0, line 1, column 1; an end-of-text word returns the scanner,
// but not the queue, to that state after flushing any pending token and emitting eof
module source_byte_tokenizer import sbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  byte_word_t  byte_word,
  output logic        token_valid,
  input  logic        token_stall,
  output token_word_t token_word
);

  logic      take;
  logic      q_full;
  scan_out_t scan_res;

  // a byte is taken whenever the queue can absorb its worst case
  assign byte_stall = q_full;
  assign take       = byte_valid & ~q_full;

  // mode machine, position counters and token decision
  sbt_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .word   (byte_word),
    .result (scan_res)
  );

  // output queue parts the token side from the byte side
  sbt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .wr    (scan_res),
    .full  (q_full),
    .valid (token_valid),
    .stall (token_stall),
    .word  (token_word)
  );

endmodule
